// ===== rtl/core/deq_pkg.sv =====
// Package for the double-ended queue: sizes, operation codes, transaction
// structs, command/status structs and ring index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int WORD_W  = 32;
   localparam int FILL_W  = 5;
   localparam int KIND_W  = 3;

   localparam logic [WORD_W-1:0] EMPTY_WORD = 32'h7FFF_FFFF;

   localparam logic [KIND_W-1:0] OP_PUSH_HEAD = 3'd0;
   localparam logic [KIND_W-1:0] OP_PUSH_TAIL = 3'd1;
   localparam logic [KIND_W-1:0] OP_POP_HEAD  = 3'd2;
   localparam logic [KIND_W-1:0] OP_POP_TAIL  = 3'd3;
   localparam logic [KIND_W-1:0] OP_DOUBLE    = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic                     was_empty;
      logic                     was_full;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [FILL_W-1:0]        fill_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic push_head;
      logic push_tail;
      logic pop_head;
      logic pop_tail;
      logic flag_full;
      logic flag_empty;
      logic pop_take;
      logic dbl_start;
      logic dbl_read;
      logic dbl_write;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              dbl_last;
   } status_type;

   // (base + offset) mod DEPTH; base < DEPTH and offset <= DEPTH
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] prev;
      if (base == '0) begin
         prev = IDX_W'(DEPTH - 1);
      end else begin
         prev = base - IDX_W'(1);
      end
      return prev;
   endfunction

   // low FILL_W bits of the count, whatever the count width
   function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] count);
      logic [CNT_W+FILL_W-1:0] wide;
      wide = (CNT_W + FILL_W)'(count);
      return wide[FILL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// Sequencing state machine for the double-ended queue.
// Depends on deq_pkg (cmd_type, status_type, operation codes).
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire deq_pkg::status_type status,
   output deq_pkg::cmd_type         cmd,
   output logic                     busy,
   output logic                     rsp_strobe
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_OP     = 3'd1;
   localparam logic [2:0] S_POPRD  = 3'd2;
   localparam logic [2:0] S_DBL_RD = 3'd3;
   localparam logic [2:0] S_DBL_WR = 3'd4;
   localparam logic [2:0] S_LOOK   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_OP;
            end
         end
         S_OP: begin
            state_in = S_LOOK;
            case (status.kind)
               deq_pkg::OP_PUSH_HEAD: begin
                  if (status.full) cmd.flag_full = 1'b1;
                  else             cmd.push_head = 1'b1;
               end
               deq_pkg::OP_PUSH_TAIL: begin
                  if (status.full) cmd.flag_full = 1'b1;
                  else             cmd.push_tail = 1'b1;
               end
               deq_pkg::OP_POP_HEAD: begin
                  if (status.empty) begin
                     cmd.flag_empty = 1'b1;
                  end else begin
                     cmd.pop_head = 1'b1;
                     state_in     = S_POPRD;
                  end
               end
               deq_pkg::OP_POP_TAIL: begin
                  if (status.empty) begin
                     cmd.flag_empty = 1'b1;
                  end else begin
                     cmd.pop_tail = 1'b1;
                     state_in     = S_POPRD;
                  end
               end
               deq_pkg::OP_DOUBLE: begin
                  if (!status.empty) begin
                     cmd.dbl_start = 1'b1;
                     state_in      = S_DBL_RD;
                  end
               end
               default: begin
                  state_in = S_LOOK;
               end
            endcase
         end
         S_POPRD: begin
            cmd.pop_take = 1'b1;
            state_in     = S_LOOK;
         end
         S_DBL_RD: begin
            cmd.dbl_read = 1'b1;
            state_in     = S_DBL_WR;
         end
         S_DBL_WR: begin
            cmd.dbl_write = 1'b1;
            state_in      = status.dbl_last ? S_LOOK : S_DBL_RD;
         end
         S_LOOK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/deq_dpath.sv =====
// Datapath of the double-ended queue: ring memory, head index, count,
// doubling index and result registers.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_dpath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire deq_pkg::req_type    req_item,
   input  wire deq_pkg::cmd_type    cmd,
   output deq_pkg::status_type      status,
   output deq_pkg::rsp_type         rsp_item
);

   logic [deq_pkg::WORD_W-1:0] ring_mem [deq_pkg::DEPTH];

   logic [deq_pkg::KIND_W-1:0] kind_ff;
   logic [deq_pkg::WORD_W-1:0] value_ff;
   logic [deq_pkg::IDX_W-1:0]  front_ff, front_in;
   logic [deq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [deq_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [deq_pkg::WORD_W-1:0] popped_ff, popped_in;
   logic                       empty_ff, empty_in;
   logic                       full_ff, full_in;
   logic [deq_pkg::WORD_W-1:0] rd_a_ff, rd_b_ff;

   logic [deq_pkg::CNT_W-1:0]  back_off;
   logic [deq_pkg::IDX_W-1:0]  back_slot;
   logic [deq_pkg::IDX_W-1:0]  walk_slot;
   logic [deq_pkg::IDX_W-1:0]  rd_a_addr;
   logic [deq_pkg::IDX_W-1:0]  wr_addr;
   logic [deq_pkg::WORD_W-1:0] wr_data;
   logic                       wr_en;
   logic                       is_empty;

   assign is_empty  = (count_ff == '0);
   assign back_off  = is_empty ? '0 : count_ff - deq_pkg::CNT_W'(1);
   assign back_slot = deq_pkg::slot_at(front_ff, back_off);
   assign walk_slot = deq_pkg::slot_at(front_ff, deq_pkg::CNT_W'(idx_ff));

   assign status.kind     = kind_ff;
   assign status.full     = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign status.empty    = is_empty;
   assign status.dbl_last = ((deq_pkg::CNT_W'(idx_ff) + deq_pkg::CNT_W'(1)) == count_ff);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      popped_in = popped_ff;
      empty_in  = empty_ff;
      full_in   = full_ff;
      rd_a_addr = front_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      wr_data   = value_ff;

      if (cmd.capture) begin
         popped_in = '0;
         empty_in  = 1'b0;
         full_in   = 1'b0;
      end
      if (cmd.flag_full) begin
         full_in = 1'b1;
      end
      if (cmd.flag_empty) begin
         empty_in  = 1'b1;
         popped_in = deq_pkg::EMPTY_WORD;
      end
      if (cmd.push_head) begin
         wr_en    = 1'b1;
         wr_addr  = deq_pkg::slot_before(front_ff);
         front_in = deq_pkg::slot_before(front_ff);
         count_in = count_ff + deq_pkg::CNT_W'(1);
      end
      if (cmd.push_tail) begin
         wr_en    = 1'b1;
         wr_addr  = deq_pkg::slot_at(front_ff, count_ff);
         count_in = count_ff + deq_pkg::CNT_W'(1);
      end
      if (cmd.pop_head) begin
         rd_a_addr = front_ff;
         front_in  = deq_pkg::slot_at(front_ff, deq_pkg::CNT_W'(1));
         count_in  = count_ff - deq_pkg::CNT_W'(1);
      end
      if (cmd.pop_tail) begin
         rd_a_addr = back_slot;
         count_in  = count_ff - deq_pkg::CNT_W'(1);
      end
      if (cmd.pop_take) begin
         popped_in = rd_a_ff;
      end
      if (cmd.dbl_start) begin
         idx_in = '0;
      end
      if (cmd.dbl_read) begin
         rd_a_addr = walk_slot;
      end
      if (cmd.dbl_write) begin
         wr_en   = 1'b1;
         wr_addr = walk_slot;
         wr_data = {rd_a_ff[deq_pkg::WORD_W-2:0], 1'b0};
         idx_in  = idx_ff + deq_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_item.kind;
         value_ff <= req_item.push_value;
      end
      idx_ff    <= idx_in;
      popped_ff <= popped_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
   end

   // ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= ring_mem[rd_a_addr];
      rd_b_ff <= ring_mem[back_slot];
   end

   assign rsp_item.popped_value = popped_ff;
   assign rsp_item.was_empty    = empty_ff;
   assign rsp_item.was_full     = full_ff;
   assign rsp_item.front_value  = is_empty ? deq_pkg::EMPTY_WORD : rd_a_ff;
   assign rsp_item.back_value   = is_empty ? deq_pkg::EMPTY_WORD : rd_b_ff;
   assign rsp_item.fill_count   = deq_pkg::fill_of(count_ff);

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | handshake          | payload            | direction
//  ----------+--------------------+--------------------+----------
//  request   | start / busy       | req_item (req_type)| in
//  response  | rsp_strobe         | rsp_item (rsp_type)| out
//
// A request transaction is taken when start is high and busy is low.
// Sequence: every accepted transaction passes through the operation state,
// a look state and the done state in which the strobe is high. A pop of a
// non-empty queue adds a read state; a doubling of a non-empty queue adds a
// read and a write state per stored word on the single-write ring memory.
// busy stays high from acceptance until the strobe cycle has ended, so the
// next transaction is taken in the cycle after the strobe at the earliest.
// Reset (synchronous, active high) empties the queue; ring contents are kept.
// The response is shown for exactly one cycle and cannot be stalled.

module double_ended_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire deq_pkg::req_type  req_item,
   output logic                   rsp_strobe,
   output deq_pkg::rsp_type       rsp_item
);

   deq_pkg::cmd_type    cmd;
   deq_pkg::status_type status;

   // sequencer: walks each transaction through its cycles
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // ring memory, pointers and the result registers
   deq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // the strobe only comes out of a transaction in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe outside a transaction");

   // an accepted transaction makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // one response per transaction: the strobe never stays high on consecutive clock edges
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // count never exceeds the ring depth; empty and full never flagged together
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.fill_count <= deq_pkg::FILL_W'(deq_pkg::DEPTH)) &&
         !(rsp_item.was_empty && rsp_item.was_full))
      else $error("count above depth or empty and full flags raised together");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the double_ended_queue block: a mirror of the
// ring predicts each response, and the block is driven through start/busy.
// Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module tb;

   import deq_pkg::*;

   // Mirror of the deque. Every accepted command updates its own copy of the
   // ring and queues the response the block must give. Each strobed response
   // is checked against the oldest one queued.
   class deque_mirror;
      logic [WORD_W-1:0] ring [DEPTH];
      int unsigned       head_slot = 0;
      int unsigned       held = 0;
      rsp_type           awaited [$];
      int unsigned       mismatches = 0;
      int unsigned       strays = 0;
      int unsigned       matched = 0;
      int unsigned       full_drops = 0;
      int unsigned       empty_pops = 0;
      int unsigned       peak_fill = 0;

      function void apply(req_type cmd);
         rsp_type     r;
         int unsigned s;
         r = '0;
         case (cmd.kind)
            OP_PUSH_HEAD: begin
               if (held >= DEPTH) begin
                  r.was_full = 1'b1;
                  full_drops++;
               end else begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring[head_slot] = cmd.push_value;
                  held++;
               end
            end
            OP_PUSH_TAIL: begin
               if (held >= DEPTH) begin
                  r.was_full = 1'b1;
                  full_drops++;
               end else begin
                  ring[(head_slot + held) % DEPTH] = cmd.push_value;
                  held++;
               end
            end
            OP_POP_HEAD: begin
               if (held == 0) begin
                  r.popped_value = EMPTY_WORD;
                  r.was_empty = 1'b1;
                  empty_pops++;
               end else begin
                  r.popped_value = ring[head_slot];
                  head_slot = (head_slot + 1) % DEPTH;
                  held--;
               end
            end
            OP_POP_TAIL: begin
               if (held == 0) begin
                  r.popped_value = EMPTY_WORD;
                  r.was_empty = 1'b1;
                  empty_pops++;
               end else begin
                  r.popped_value = ring[(head_slot + held - 1) % DEPTH];
                  held--;
               end
            end
            OP_DOUBLE: begin
               for (int unsigned i = 0; i < held; i++) begin
                  s = (head_slot + i) % DEPTH;
                  ring[s] = {ring[s][WORD_W-2:0], 1'b0};
               end
            end
            default: begin
            end
         endcase
         if (held == 0) begin
            r.front_value = EMPTY_WORD;
            r.back_value = EMPTY_WORD;
         end else begin
            r.front_value = ring[head_slot];
            r.back_value = ring[(head_slot + held - 1) % DEPTH];
         end
         r.fill_count = FILL_W'(held);
         if (held > peak_fill) begin
            peak_fill = held;
         end
         awaited.push_back(r);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         bit      bad;
         if (awaited.size() == 0) begin
            strays++;
            if (mismatches + strays <= 10) begin
               $display("%0t: response with nothing outstanding: popped %h fill %0d",
                        $realtime, got.popped_value, got.fill_count);
            end
            return;
         end
         want = awaited.pop_front();
         bad = (got.popped_value !== want.popped_value) ||
               (got.was_empty !== want.was_empty) ||
               (got.was_full !== want.was_full) ||
               (got.front_value !== want.front_value) ||
               (got.back_value !== want.back_value) ||
               (got.fill_count !== want.fill_count);
         if (!bad) begin
            matched++;
            return;
         end
         mismatches++;
         if (mismatches + strays <= 10) begin
            $display("%0t: mismatch  exp pop %h e%b f%b front %h back %h fill %0d",
                     $realtime, want.popped_value, want.was_empty, want.was_full,
                     want.front_value, want.back_value, want.fill_count);
            $display("%0t:           got pop %h e%b f%b front %h back %h fill %0d",
                     $realtime, got.popped_value, got.was_empty, got.was_full,
                     got.front_value, got.back_value, got.fill_count);
         end
      endfunction

      function int unsigned failures();
         return mismatches + strays + awaited.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   deque_mirror mirror = new();

   // transactions issued per kind code, for the closing summary
   int unsigned kind_seen [8];

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // Response side cannot stall: every strobe is a transaction. Values read
   // straight after the edge are the ones the edge sampled.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         mirror.check(rsp_item);
      end
   end

   // Hang guard; the slowest legal run (all doublings at full fill plus
   // maximum gaps) is well under a tenth of this.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type cmd_of(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
      req_type c;
      c.kind = kind;
      c.push_value = value;
      return c;
   endfunction

   // Words that sit on the edges of the signed range, or flip sign when doubled.
   function automatic logic [WORD_W-1:0] edgy_word();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h4000_0000;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // One random command. push_pct sets how hard the fill level is pushed
   // upwards; apart from doublings and unused codes, the rest of the traffic is pops.
   function automatic req_type random_cmd(int unsigned push_pct);
      logic [WORD_W-1:0] w;
      int unsigned       r;
      w = ($urandom_range(9) < 3) ? edgy_word() : $urandom;
      r = $urandom_range(99);
      if (r < 3) begin
         return cmd_of(KIND_W'($urandom_range(7, 5)), w);
      end else if (r < 10) begin
         return cmd_of(OP_DOUBLE, w);
      end else if ($urandom_range(99) < push_pct) begin
         return cmd_of($urandom_range(1) ? OP_PUSH_TAIL : OP_PUSH_HEAD, w);
      end
      return cmd_of($urandom_range(1) ? OP_POP_TAIL : OP_POP_HEAD, w);
   endfunction

   // Entered and left on a falling edge. A zero gap keeps start high straight
   // into the next transaction, so start is never dropped and raised in one
   // step. The command is taken at the first rising edge with busy low.
   task automatic send(req_type cmd, int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= cmd;
      do begin
         @(posedge clock);
      end while (busy);
      mirror.apply(cmd);
      kind_seen[cmd.kind]++;
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding response has been seen.
   task automatic drain();
      start <= 1'b0;
      while (mirror.awaited.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   initial begin
      req_type     directed [$];
      int unsigned push_pct;
      bit          idling;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty pops both ends, doubling nothing, an unused code,
      // last word popped, then fill to the brim, overflow both ends and
      // double a full ring so the sign bit is shifted out.
      directed.push_back(cmd_of(OP_POP_HEAD, 32'h1234_5678));
      directed.push_back(cmd_of(OP_POP_TAIL, 32'hFFFF_FFFF));
      directed.push_back(cmd_of(OP_DOUBLE, 32'h0));
      directed.push_back(cmd_of(3'd7, 32'hFFFF_FFFF));
      directed.push_back(cmd_of(OP_PUSH_HEAD, 32'h7FFF_FFFF));
      directed.push_back(cmd_of(OP_DOUBLE, 32'h0));
      directed.push_back(cmd_of(OP_POP_TAIL, 32'h0));
      for (int i = 0; i < DEPTH; i++) begin
         directed.push_back(cmd_of((i % 2) ? OP_PUSH_TAIL : OP_PUSH_HEAD,
                                   (i < 4) ? {i[0], {31{i[1]}}} : $urandom));
      end
      directed.push_back(cmd_of(OP_PUSH_HEAD, 32'h8000_0000));
      directed.push_back(cmd_of(OP_PUSH_TAIL, 32'h7FFF_FFFF));
      directed.push_back(cmd_of(OP_DOUBLE, 32'hFFFF_FFFF));
      foreach (directed[i]) begin
         send(directed[i], $urandom_range(3));
      end
      drain();

      // Random: bursts of fifty that lean towards filling, emptying or
      // hovering, so full and empty are both reached again and again.
      for (int burst = 0; burst < 18; burst++) begin
         case (burst % 3)
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
         endcase
         idling = (burst % 4 != 0) && ($urandom_range(3) != 0);
         for (int n = 0; n < 50; n++) begin
            send(random_cmd(push_pct), idling ? $urandom_range(3) : 0);
         end
         if (burst == 9) begin
            drain();
         end
      end

      drain();
      repeat (2 * DEPTH + 8) @(posedge clock);

      $display("covered %0d push-head, %0d push-tail, %0d pop-head, %0d pop-tail, %0d double",
               kind_seen[OP_PUSH_HEAD], kind_seen[OP_PUSH_TAIL], kind_seen[OP_POP_HEAD],
               kind_seen[OP_POP_TAIL], kind_seen[OP_DOUBLE]);
      $display("plus %0d unused codes; %0d dropped pushes, %0d empty pops, peak fill %0d, %0d ok",
               kind_seen[5] + kind_seen[6] + kind_seen[7], mirror.full_drops,
               mirror.empty_pops, mirror.peak_fill, mirror.matched);
      if (mirror.failures() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
